>>> hw/rtl/ctmc_pkg.sv
// Shared constants, types and helpers for the checksum tolerant match check.
package ctmc_pkg;

    localparam int MAX_WORD_BITS = 32;
    localparam int MAX_FLIPS     = 8;
    localparam int POS_W         = $clog2(MAX_WORD_BITS);
    localparam int WCNT_W        = $clog2(MAX_WORD_BITS + 1);
    localparam int K_W           = $clog2(MAX_FLIPS + 1);
    localparam int FLIP_IDX_W    = (MAX_FLIPS > 1) ? $clog2(MAX_FLIPS) : 1;

    localparam int MSG_W         = 24;
    localparam int CHK_W         = 8;
    localparam int MB_W          = 5;
    localparam int CB_W          = 4;
    localparam int TOL_W         = 4;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 24;

    localparam logic [9:0] CHK_OFFSET = 10'd9;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SECRET   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXP_CHK  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MSG_BITS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHK_BITS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOL      = 3'd4;

    // Result codes
    typedef enum logic [1:0] {
        OUT_FAR    = 2'd0,
        OUT_SECRET = 2'd1,
        OUT_OTHER  = 2'd2,
        OUT_NONE   = 2'd3
    } t_outcome;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_SEARCH,
        ST_EMIT
    } t_state;

    // Mask of the low n bits of a word, n up to MAX_WORD_BITS
    function automatic logic [MAX_WORD_BITS-1:0] low_mask(input logic [WCNT_W-1:0] n);
        logic [MAX_WORD_BITS:0] t;
        t = ({{MAX_WORD_BITS{1'b0}}, 1'b1} << n) - {{MAX_WORD_BITS{1'b0}}, 1'b1};
        return t[MAX_WORD_BITS-1:0];
    endfunction

    // Population count: nibble counts, then a short chain over the nibbles
    function automatic logic [WCNT_W-1:0] pop_count(input logic [MAX_WORD_BITS-1:0] v);
        logic [MAX_WORD_BITS+3:0] padded;
        logic [WCNT_W-1:0]        sum;
        logic [2:0]               nib;
        padded = {4'b0, v};
        sum    = '0;
        for (int g = 0; g < (MAX_WORD_BITS + 3) / 4; g++) begin
            nib = {2'b0, padded[4*g]} + {2'b0, padded[4*g+1]}
                + {2'b0, padded[4*g+2]} + {2'b0, padded[4*g+3]};
            sum = sum + WCNT_W'(nib);
        end
        return sum;
    endfunction

endpackage

>>> hw/rtl/checksum_tolerant_match_check.sv
// Top level: tolerant match of a hash word against secret message plus checksum.
// Sequence: a setup state, then one flip pattern tested per cycle, then an emit state that
//   loads the output register; a too-distant word goes from setup straight to emit.
// Throughput: one item at a time; the input stalls until the result is loaded, and the
//   search tests at most the sum over k = 0..tolerance of C(W, k) patterns (2325 at reset
//   settings); an output stall holds the emit state.
// Reset: synchronous active-low; clears control state and restores register defaults.
module checksum_tolerant_match_check (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [31:0]                     i_hash_value,
    // output channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_hit,
    output logic [1:0]                      o_outcome,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ctmc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ctmc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int WB = ctmc_pkg::MAX_WORD_BITS;
    localparam int NF = ctmc_pkg::MAX_FLIPS;

    // configuration registers
    logic [ctmc_pkg::MSG_W-1:0] r_secret;
    logic [ctmc_pkg::CHK_W-1:0] r_exp_chk;
    logic [ctmc_pkg::MB_W-1:0]  r_msg_bits;
    logic [ctmc_pkg::CB_W-1:0]  r_chk_bits;
    logic [ctmc_pkg::TOL_W-1:0] r_tol;

    // sequencer state
    ctmc_pkg::t_state           r_state, n_state;
    logic [WB-1:0]              r_held_word, n_held_word;
    logic [ctmc_pkg::K_W-1:0]   r_k, n_k;
    logic [ctmc_pkg::POS_W-1:0] r_pos [NF];
    logic [ctmc_pkg::POS_W-1:0] n_pos [NF];
    ctmc_pkg::t_outcome         r_res, n_res;

    // output register
    logic                       r_out_valid, n_out_valid;
    ctmc_pkg::t_outcome         r_outcome, n_outcome;

    // effective widths
    logic [ctmc_pkg::MB_W-1:0]   mb;
    logic [ctmc_pkg::CB_W-1:0]   cb;
    logic [ctmc_pkg::WCNT_W-1:0] w;
    logic [ctmc_pkg::K_W-1:0]    tol_eff;
    logic [WB-1:0]               w_mask;
    logic [ctmc_pkg::CHK_W-1:0]  cm;
    logic [ctmc_pkg::MSG_W-1:0]  sec;
    logic [WB-1:0]               ref_word;
    logic [ctmc_pkg::WCNT_W-1:0] ham_dist;

    // pattern test
    logic [WB-1:0]              flip_mask;
    logic [WB-1:0]              cw;
    logic [WB-1:0]              msg;
    logic [ctmc_pkg::CHK_W-1:0] chk_field;
    logic [ctmc_pkg::CHK_W-1:0] chunk0, chunk1, chunk2;
    logic [9:0]                 fold_sum;
    logic                       chk_ok;

    // subset advance
    logic [NF-1:0]                   can_bump;
    logic                            bump_found;
    logic [ctmc_pkg::FLIP_IDX_W-1:0] bump_idx;
    logic [ctmc_pkg::POS_W-1:0]      bump_base;

    logic in_acc;
    logic out_free;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != ctmc_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_outcome   = r_outcome;
    assign o_hit       = (r_outcome == ctmc_pkg::OUT_SECRET);

    // saturate the register settings
    always_comb begin
        if (r_msg_bits == '0) begin
            mb = ctmc_pkg::MB_W'(1);
        end else if (r_msg_bits > ctmc_pkg::MB_W'(ctmc_pkg::MSG_W)) begin
            mb = ctmc_pkg::MB_W'(ctmc_pkg::MSG_W);
        end else begin
            mb = r_msg_bits;
        end
        if (r_chk_bits == '0) begin
            cb = ctmc_pkg::CB_W'(1);
        end else if (r_chk_bits > ctmc_pkg::CB_W'(ctmc_pkg::CHK_W)) begin
            cb = ctmc_pkg::CB_W'(ctmc_pkg::CHK_W);
        end else begin
            cb = r_chk_bits;
        end
        w = ctmc_pkg::WCNT_W'(mb) + ctmc_pkg::WCNT_W'(cb);
        if (r_tol > ctmc_pkg::TOL_W'(NF)) begin
            tol_eff = ctmc_pkg::K_W'(NF);
        end else begin
            tol_eff = ctmc_pkg::K_W'(r_tol);
        end
        if (ctmc_pkg::WCNT_W'(tol_eff) > w) begin
            tol_eff = ctmc_pkg::K_W'(w);
        end
        w_mask   = ctmc_pkg::low_mask(w);
        cm       = ctmc_pkg::CHK_W'(ctmc_pkg::low_mask(ctmc_pkg::WCNT_W'(cb)));
        sec      = r_secret & ctmc_pkg::MSG_W'(ctmc_pkg::low_mask(ctmc_pkg::WCNT_W'(mb)));
        ref_word = WB'(sec) | (WB'(r_exp_chk & cm) << mb);
        ham_dist = ctmc_pkg::pop_count((r_held_word ^ ref_word) & w_mask);
    end

    // apply the current flip pattern and run the folding checksum
    always_comb begin
        flip_mask = '0;
        for (int i = 0; i < NF; i++) begin
            if (ctmc_pkg::K_W'(i) < r_k) begin
                flip_mask = flip_mask | (WB'(1) << r_pos[i]);
            end
        end
        cw        = r_held_word ^ flip_mask;
        msg       = cw & ctmc_pkg::low_mask(ctmc_pkg::WCNT_W'(mb));
        chk_field = ctmc_pkg::CHK_W'(cw >> mb) & cm;
        chunk0    = msg[ctmc_pkg::CHK_W-1:0] & cm;
        chunk1    = (mb > ctmc_pkg::MB_W'(cb)) ? (ctmc_pkg::CHK_W'(msg >> cb) & cm) : '0;
        chunk2    = (mb > {cb, 1'b0}) ? (ctmc_pkg::CHK_W'(msg >> {cb, 1'b0}) & cm) : '0;
        fold_sum  = 10'(chunk0) + 10'(chunk1) + 10'(chunk2) + ctmc_pkg::CHK_OFFSET;
        chk_ok    = ((fold_sum[ctmc_pkg::CHK_W-1:0] & cm) == chk_field);
    end

    // find the rightmost position that can still move up
    always_comb begin
        bump_found = 1'b0;
        bump_idx   = '0;
        for (int i = 0; i < NF; i++) begin
            can_bump[i] = (ctmc_pkg::K_W'(i) < r_k)
                && ({2'b0, r_pos[i]} < (7'(w) - 7'(r_k) + 7'(i)));
            if (can_bump[i]) begin
                bump_found = 1'b1;
                bump_idx   = ctmc_pkg::FLIP_IDX_W'(i);
            end
        end
        bump_base = r_pos[bump_idx];
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_held_word = r_held_word;
        n_k         = r_k;
        n_res       = r_res;
        n_out_valid = r_out_valid && i_out_stall;
        n_outcome   = r_outcome;
        for (int i = 0; i < NF; i++) begin
            n_pos[i] = r_pos[i];
        end
        case (r_state)
            ctmc_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_held_word = i_hash_value & w_mask;
                    n_state     = ctmc_pkg::ST_PREP;
                end
            end
            ctmc_pkg::ST_PREP: begin
                if (ctmc_pkg::WCNT_W'(ham_dist) > ctmc_pkg::WCNT_W'(tol_eff)) begin
                    n_res   = ctmc_pkg::OUT_FAR;
                    n_state = ctmc_pkg::ST_EMIT;
                end else begin
                    n_k = tol_eff;
                    for (int i = 0; i < NF; i++) begin
                        n_pos[i] = ctmc_pkg::POS_W'(i);
                    end
                    n_state = ctmc_pkg::ST_SEARCH;
                end
            end
            ctmc_pkg::ST_SEARCH: begin
                if (chk_ok) begin
                    n_res   = (msg[ctmc_pkg::MSG_W-1:0] == sec) ? ctmc_pkg::OUT_SECRET
                                                               : ctmc_pkg::OUT_OTHER;
                    n_state = ctmc_pkg::ST_EMIT;
                end else if (bump_found) begin
                    for (int i = 0; i < NF; i++) begin
                        if (ctmc_pkg::FLIP_IDX_W'(i) == bump_idx) begin
                            n_pos[i] = bump_base + ctmc_pkg::POS_W'(1);
                        end else if (ctmc_pkg::FLIP_IDX_W'(i) > bump_idx) begin
                            n_pos[i] = bump_base + ctmc_pkg::POS_W'(i)
                                     - ctmc_pkg::POS_W'(bump_idx) + ctmc_pkg::POS_W'(1);
                        end
                    end
                end else if (r_k == '0) begin
                    n_res   = ctmc_pkg::OUT_NONE;
                    n_state = ctmc_pkg::ST_EMIT;
                end else begin
                    // drop to one flip fewer and restart at the first subset
                    n_k = r_k - ctmc_pkg::K_W'(1);
                    for (int i = 0; i < NF; i++) begin
                        n_pos[i] = ctmc_pkg::POS_W'(i);
                    end
                end
            end
            ctmc_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_outcome   = r_res;
                    n_state     = ctmc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ctmc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ctmc_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_held_word <= '0;
            r_k         <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_held_word <= n_held_word;
            r_k         <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res     <= n_res;
        r_outcome <= n_outcome;
        for (int i = 0; i < NF; i++) begin
            r_pos[i] <= n_pos[i];
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_secret   <= '0;
            r_exp_chk  <= ctmc_pkg::CHK_W'(9);
            r_msg_bits <= ctmc_pkg::MB_W'(16);
            r_chk_bits <= ctmc_pkg::CB_W'(8);
            r_tol      <= ctmc_pkg::TOL_W'(3);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ctmc_pkg::REG_SECRET:   r_secret   <= i_cfg_data[ctmc_pkg::MSG_W-1:0];
                ctmc_pkg::REG_EXP_CHK:  r_exp_chk  <= i_cfg_data[ctmc_pkg::CHK_W-1:0];
                ctmc_pkg::REG_MSG_BITS: r_msg_bits <= i_cfg_data[ctmc_pkg::MB_W-1:0];
                ctmc_pkg::REG_CHK_BITS: r_chk_bits <= i_cfg_data[ctmc_pkg::CB_W-1:0];
                ctmc_pkg::REG_TOL:      r_tol      <= i_cfg_data[ctmc_pkg::TOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // an accepted transaction always starts with the setup cycle
    a_accept_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == ctmc_pkg::ST_PREP))
        else $error("accepted transaction did not enter setup");

    // the search never runs with more flips than the tolerance allows
    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ctmc_pkg::ST_SEARCH) |-> (r_k <= tol_eff))
        else $error("flip count above tolerance");

    // the first two flip positions stay strictly increasing while searching with two or more flips
    a_pos_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ctmc_pkg::ST_SEARCH) && (r_k >= ctmc_pkg::K_W'(2)))
            |-> (r_pos[0] < r_pos[1]))
        else $error("flip positions out of order");

    // a new result is loaded only into a free output register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> $stable(r_outcome))
        else $error("pending result overwritten");

endmodule

>>> tb/tb_checksum_tolerant_match_check.sv
// Testbench for the checksum tolerant match check: directed and random words vs a predictor.
module tb_checksum_tolerant_match_check;
    import ctmc_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 8;
    localparam int IDLE_PCT      = 27;
    localparam int CLOSE_CYCLES  = 20;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 25;
    localparam int COST_LIMIT    = 3000;
    localparam int CHK_ADD       = 9;
    localparam longint TIMEOUT   = 200_000_000;

    typedef struct packed {
        logic [MSG_W-1:0] secret;
        logic [CHK_W-1:0] exp_chk;
        logic [MB_W-1:0]  msg_bits;
        logic [CB_W-1:0]  chk_bits;
        logic [TOL_W-1:0] tol;
    } t_settings;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic [31:0]           i_hash_value = '0;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic                  o_hit;
    logic [1:0]            o_outcome;
    logic                  o_cfg_ready;

    // register copy as the block should hold it, starting from reset values
    t_settings regs = '{secret: '0, exp_chk: 8'd9, msg_bits: 5'd16, chk_bits: 4'd8, tol: 4'd3};
    t_outcome  pending_outcomes [$];
    bit        idle_en = 1'b1;
    int        fail_count = 0;

    checksum_tolerant_match_check dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_hash_value (i_hash_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_hit        (o_hit),
        .o_outcome    (o_outcome),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    function automatic logic [31:0] bits_below(input int n);
        return (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
    endfunction

    // saturate widths and tolerance the way the block does
    function automatic void clamp_settings(input t_settings s, output int mb, output int cb,
                                           output int tol);
        mb = s.msg_bits;
        cb = s.chk_bits;
        tol = s.tol;
        if (mb < 1) mb = 1;
        if (mb > MSG_W) mb = MSG_W;
        if (cb < 1) cb = 1;
        if (cb > CHK_W) cb = CHK_W;
        if (mb + cb > MAX_WORD_BITS) mb = MAX_WORD_BITS - cb;
        if (tol > MAX_FLIPS) tol = MAX_FLIPS;
        if (tol > mb + cb) tol = mb + cb;
    endfunction

    function automatic int checksum_fold(input logic [31:0] m, input int mb, input int cb);
        logic [31:0] cm;
        int          sum;
        cm = bits_below(cb);
        sum = m & cm;
        if (mb > cb) sum += (m >> cb) & cm;
        if (mb > 2 * cb) sum += (m >> (2 * cb)) & cm;
        return (sum + CHK_ADD) & cm;
    endfunction

    function automatic logic [31:0] reference_word(input t_settings s, input int mb, input int cb);
        return (32'(s.secret) & bits_below(mb)) | ((32'(s.exp_chk) & bits_below(cb)) << mb);
    endfunction

    // tolerant decode: flip counts high to low, subsets in lexicographic order
    function automatic t_outcome predict_outcome(input logic [31:0] hash);
        int          mb, cb, tol, w, kk, i, j;
        int          pos [MAX_FLIPS];
        logic [31:0] word, sec, cw, m, c;
        bit          more;
        t_outcome    res;
        clamp_settings(regs, mb, cb, tol);
        w = mb + cb;
        word = hash & bits_below(w);
        sec = 32'(regs.secret) & bits_below(mb);
        if ($countones(word ^ reference_word(regs, mb, cb)) > tol) return OUT_FAR;
        res = OUT_NONE;
        for (kk = tol; kk >= 0 && res == OUT_NONE; kk--) begin
            for (i = 0; i < kk; i++) pos[i] = i;
            more = 1'b1;
            while (more) begin
                cw = word;
                for (i = 0; i < kk; i++) cw ^= 32'd1 << pos[i];
                m = cw & bits_below(mb);
                c = (cw >> mb) & bits_below(cb);
                if (checksum_fold(m, mb, cb) == c) begin
                    res = (m == sec) ? OUT_SECRET : OUT_OTHER;
                    more = 1'b0;
                end else begin
                    j = kk - 1;
                    while (j >= 0 && pos[j] == w - kk + j) j--;
                    if (j < 0) begin
                        more = 1'b0;
                    end else begin
                        pos[j]++;
                        for (i = j + 1; i < kk; i++) pos[i] = pos[i-1] + 1;
                    end
                end
            end
        end
        return res;
    endfunction

    function automatic void store_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_SECRET:   regs.secret   = data[MSG_W-1:0];
            REG_EXP_CHK:  regs.exp_chk  = data[CHK_W-1:0];
            REG_MSG_BITS: regs.msg_bits = data[MB_W-1:0];
            REG_CHK_BITS: regs.chk_bits = data[CB_W-1:0];
            REG_TOL:      regs.tol      = data[TOL_W-1:0];
            default: ;
        endcase
    endfunction

    // worst-case number of patterns the search may walk through
    function automatic longint search_cost(input t_settings s);
        int     mb, cb, tol, w, k;
        longint term, total;
        clamp_settings(s, mb, cb, tol);
        w = mb + cb;
        term = 1;
        total = 1;
        for (k = 1; k <= tol; k++) begin
            term = term * (w - k + 1) / k;
            total += term;
        end
        return total;
    endfunction

    function automatic t_settings pick_settings();
        t_settings s;
        int        mb, cb, tol;
        do begin
            s.secret   = MSG_W'($urandom);
            s.exp_chk  = CHK_W'($urandom);
            s.msg_bits = MB_W'($urandom_range(31));
            s.chk_bits = CB_W'($urandom_range(15));
            s.tol      = TOL_W'($urandom_range(15));
        end while (search_cost(s) > COST_LIMIT);
        clamp_settings(s, mb, cb, tol);
        // mostly a consistent reference word, so that decodes land on the secret
        if ($urandom_range(9) < 7)
            s.exp_chk = CHK_W'(checksum_fold(32'(s.secret) & bits_below(mb), mb, cb))
                      | (CHK_W'($urandom) & ~CHK_W'(bits_below(cb)));
        return s;
    endfunction

    // reference word with a few flipped bits and random bits above the word
    function automatic logic [31:0] near_word();
        int          mb, cb, tol, w, flips;
        logic [31:0] noise;
        clamp_settings(regs, mb, cb, tol);
        w = mb + cb;
        flips = $urandom_range(tol + 1);
        if (flips > w) flips = w;
        noise = '0;
        while ($countones(noise) < flips) noise |= 32'd1 << $urandom_range(w - 1);
        return (reference_word(regs, mb, cb) ^ noise) | ($urandom & ~bits_below(w));
    endfunction

    task automatic send_hash(input logic [31:0] value);
        if (idle_en && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < IDLE_PCT);
        end
        i_in_valid   <= 1'b1;
        i_hash_value <= value;
        do @(posedge i_clk); while (o_in_stall);
        pending_outcomes.push_back(predict_outcome(value));
    endtask

    // drop valid and let every outstanding result come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
    endtask

    task automatic program_regs(input t_settings s, input bit add_stray);
        logic [CFG_IDX_W-1:0]  idx_list  [$];
        logic [CFG_DATA_W-1:0] data_list [$];
        int                    n;
        int                    pos_at;
        idx_list  = '{REG_SECRET, REG_EXP_CHK, REG_MSG_BITS, REG_CHK_BITS, REG_TOL};
        data_list = '{s.secret,
                      {16'($urandom), s.exp_chk},
                      {19'($urandom), s.msg_bits},
                      {20'($urandom), s.chk_bits},
                      {20'($urandom), s.tol}};
        if (add_stray) begin
            pos_at = $urandom_range(idx_list.size());
            idx_list.insert(pos_at, CFG_IDX_W'($urandom_range(5, 7)));
            data_list.insert(pos_at, CFG_DATA_W'($urandom));
        end
        for (n = 0; n < idx_list.size(); n++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx_list[n];
            i_cfg_data  <= data_list[n];
            do @(posedge i_clk); while (!o_cfg_ready);
            store_reg(idx_list[n], data_list[n]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_hash(32'h0009_0000);
        send_hash(32'h0009_0001);
        send_hash(32'h000B_0005);
        send_hash(32'h0009_000F);
        send_hash(32'h0000_0000);
        send_hash(32'hFF09_0000);
        send_hash(32'hFFFF_FFFF);
        send_hash(32'h00FF_FFFF);
        wait_drained();
    endtask

    task automatic test_widest_word();
        t_settings s;
        s = '{secret: 24'hFF_FFFF, exp_chk: '0, msg_bits: 5'd24, chk_bits: 4'd8, tol: 4'd2};
        s.exp_chk = CHK_W'(checksum_fold(32'h00FF_FFFF, 24, 8));
        program_regs(s, 1'b0);
        send_hash(reference_word(s, 24, 8));
        send_hash(reference_word(s, 24, 8) ^ 32'h8000_0000);
        send_hash(reference_word(s, 24, 8) ^ 32'h0000_0001);
        send_hash(reference_word(s, 24, 8) ^ 32'h8100_0001);
        send_hash(32'hFFFF_FFFF);
        wait_drained();
    endtask

    task automatic test_width_saturation();
        t_settings s;
        // zero widths and oversize tolerance: a two-bit word searched at full depth
        s = '{secret: 24'hFF_FFFF, exp_chk: '0, msg_bits: '0, chk_bits: '0, tol: 4'd15};
        program_regs(s, 1'b1);
        send_hash(32'h0000_0000);
        send_hash(32'h0000_0001);
        send_hash(32'hFFFF_FFFE);
        send_hash(32'hFFFF_FFFF);
        wait_drained();
        // oversize widths clip to the full 32-bit word
        s = '{secret: '0, exp_chk: 8'hFF, msg_bits: 5'd31, chk_bits: 4'd15, tol: 4'd1};
        program_regs(s, 1'b1);
        send_hash(32'hAAAA_5555);
        send_hash(32'hFF00_0000);
        wait_drained();
    endtask

    task automatic test_max_tolerance();
        t_settings s;
        s = '{secret: 24'h00_0001, exp_chk: '0, msg_bits: 5'd1, chk_bits: 4'd8, tol: 4'd8};
        s.exp_chk = CHK_W'(checksum_fold(32'd1, 1, 8));
        program_regs(s, 1'b0);
        send_hash(reference_word(s, 1, 8));
        send_hash(reference_word(s, 1, 8) ^ 32'h0000_01FF);
        send_hash(reference_word(s, 1, 8) ^ 32'h0000_00FF);
        send_hash(32'hFFFF_FE00);
        wait_drained();
    endtask

    task automatic test_zero_tolerance();
        t_settings s;
        // reference word with a bad check field: nothing can be corrected
        s = '{secret: 24'h00_1234, exp_chk: '0, msg_bits: 5'd16, chk_bits: 4'd8, tol: 4'd0};
        s.exp_chk = CHK_W'(checksum_fold(32'h0000_1234, 16, 8) + 1);
        program_regs(s, 1'b0);
        send_hash(reference_word(s, 16, 8));
        send_hash(reference_word(s, 16, 8) ^ 32'h0000_0001);
        wait_drained();
    endtask

    task automatic test_random_settings();
        int phase, n;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            // one phase runs with both sides streaming
            idle_en = (phase != RANDOM_PHASES / 2);
            program_regs(pick_settings(), 1'($urandom_range(1)));
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(99) < 75)
                    send_hash(near_word());
                else
                    send_hash($urandom);
            end
            wait_drained();
        end
        idle_en = 1'b1;
    endtask

    // compare each result transaction against the oldest expectation
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_outcomes.size() == 0) begin
                $error("unexpected result: hit %0d outcome %0d", o_hit, o_outcome);
                fail_count++;
            end else begin
                want = pending_outcomes.pop_front();
                if (o_hit !== (want == OUT_SECRET)) begin
                    $error("hit: expected %0d, actual %0d", want == OUT_SECRET, o_hit);
                    fail_count++;
                end
                if (o_outcome !== want) begin
                    $error("outcome: expected %0d, actual %0d", want, o_outcome);
                    fail_count++;
                end
            end
        end
        i_out_stall <= idle_en && ($urandom_range(99) < IDLE_PCT);
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_widest_word();
        test_width_saturation();
        test_max_tolerance();
        test_zero_tolerance();
        test_random_settings();
        wait_drained();
        repeat (CLOSE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #TIMEOUT;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> checksum_tolerant_match_check.f
hw/rtl/ctmc_pkg.sv
hw/rtl/checksum_tolerant_match_check.sv
tb/tb_checksum_tolerant_match_check.sv
